### src/utf8d_pkg.sv
// Shared types, constants and the leading-ones function for the UTF-8 stream decoder.
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CpW        = 42;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned RemW       = 3;
  localparam int unsigned OutqDepth  = 8;

  localparam logic [CpW-1:0]   ReplChar  = 42'h0_0000_FFFD;
  localparam logic [1:0]       ContTag   = 2'b10;
  localparam logic [3:0]       LeadAscii = 4'd0;
  localparam logic [3:0]       LeadCont  = 4'd1;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           malformed;
    logic           last_of_run;
  } result_t;

  // Up to two results per byte; res1 is used only together with res0.
  typedef struct packed {
    logic    push0;
    logic    push1;
    result_t res0;
    result_t res1;
  } push_t;

  // Count leading ones of a byte, 0 to 8.
  function automatic logic [3:0] lead_ones(input logic [ByteW-1:0] b);
    logic [3:0] n;
    logic       stop;
    n    = 4'd0;
    stop = 1'b0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (!stop && b[i]) begin
        n = n + 4'd1;
      end else begin
        stop = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### src/utf8d_core.sv
// Input register, sequence state and per-word decode into result pushes.
`default_nettype none

module utf8d_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_take,
  input  wire logic [utf8d_pkg::ByteW-1:0] in_byte,
  input  wire logic                        in_eot,
  output utf8d_pkg::push_t                 push
);

  logic                        vld_r;
  logic [utf8d_pkg::ByteW-1:0] byte_r;
  logic                        eot_r;
  logic [utf8d_pkg::RemW-1:0]  rem_r, rem_nxt;
  logic [utf8d_pkg::CpW-1:0]   part_r, part_nxt;

  logic [3:0]                  n;
  logic                        cont;
  logic [utf8d_pkg::ByteW-1:0] lead_payload;
  logic                        fr_emit;
  logic [utf8d_pkg::CpW-1:0]   fr_cp;
  logic                        fr_bad;
  logic [utf8d_pkg::CpW-1:0]   joined;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byte_r <= in_byte;
      eot_r  <= in_eot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      part_r <= '0;
    end else if (vld_r) begin
      rem_r  <= rem_nxt;
      part_r <= part_nxt;
    end
  end

  always_comb begin
    n            = utf8d_pkg::lead_ones(byte_r);
    cont         = (byte_r[7:6] == utf8d_pkg::ContTag);
    lead_payload = byte_r & (8'hFF >> (n + 4'd1));
    // Fresh decode: ASCII or a lone continuation gives a result, a lead starts a run.
    fr_emit      = (n == utf8d_pkg::LeadAscii) || (n == utf8d_pkg::LeadCont);
    fr_bad       = (n == utf8d_pkg::LeadCont);
    fr_cp        = fr_bad ? utf8d_pkg::ReplChar
                          : {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, byte_r};
    joined       = {part_r[utf8d_pkg::CpW-7:0], byte_r[5:0]};

    rem_nxt  = rem_r;
    part_nxt = part_r;
    push     = '0;

    if (eot_r) begin
      if (rem_r != '0) begin
        push.push0 = 1'b1;
        push.res0  = '{utf8d_pkg::ReplChar, 1'b1, 1'b1};
        rem_nxt    = '0;
        part_nxt   = '0;
      end
    end else if (rem_r != '0) begin
      if (cont) begin
        rem_nxt = rem_r - 3'd1;
        if (rem_r == 3'd1) begin
          push.push0 = 1'b1;
          push.res0  = '{joined, 1'b0, 1'b1};
          part_nxt   = '0;
        end else begin
          part_nxt = joined;
        end
      end else begin
        // Broken run: replacement first, then decode the word afresh.
        push.push0 = 1'b1;
        push.res0  = '{utf8d_pkg::ReplChar, 1'b1, !fr_emit};
        push.push1 = fr_emit;
        push.res1  = '{fr_cp, fr_bad, 1'b1};
        rem_nxt    = fr_emit ? '0 : utf8d_pkg::RemW'(n - 4'd1);
        part_nxt   = fr_emit ? '0
                             : {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, lead_payload};
      end
    end else begin
      push.push0 = fr_emit;
      push.res0  = '{fr_cp, fr_bad, 1'b1};
      rem_nxt    = fr_emit ? '0 : utf8d_pkg::RemW'(n - 4'd1);
      part_nxt   = fr_emit ? '0
                           : {{(utf8d_pkg::CpW-utf8d_pkg::ByteW){1'b0}}, lead_payload};
    end

    if (!vld_r) begin
      push = '0;
    end
  end

`ifndef SYNTHESIS
  a_two_means_repl: assert property (@(posedge clk) disable iff (!rst_n)
    push.push1 |-> (push.push0 && push.res0.malformed && !push.res0.last_of_run))
    else $error("second result without a leading replacement");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && eot_r) |=> (rem_r == '0 && part_r == '0))
    else $error("end of text left a run pending");
`endif

endmodule

`default_nettype wire

### src/utf8d_outq.sv
// Result queue taking up to two results a cycle and giving one while pop_stall is low.
`default_nettype none

module utf8d_outq #(
  parameter int unsigned DEPTH = utf8d_pkg::OutqDepth
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire utf8d_pkg::push_t push,
  input  wire logic             pop_stall,
  output logic                  head_valid,
  output utf8d_pkg::result_t    head,
  output logic                  almost_full
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] StallAt = CntW'(DEPTH - 4);

  utf8d_pkg::result_t mem_r [DEPTH];
  logic [PtrW-1:0] wr_r, wr_nxt, rd_r, wr1;
  logic [CntW-1:0] count_r, count_nxt;
  logic            pop;
  logic [1:0]      npush;

  function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
    return (p == LastIdx) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr1       = inc(wr_r);
    pop       = head_valid && !pop_stall;
    npush     = {1'b0, push.push0} + {1'b0, push.push1};
    wr_nxt    = push.push1 ? inc(wr1) : (push.push0 ? wr1 : wr_r);
    count_nxt = count_r + CntW'(npush) - CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      count_r <= count_nxt;
      if (pop) begin
        rd_r <= inc(rd_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      mem_r[wr_r] <= push.res0;
    end
    if (push.push1) begin
      mem_r[wr1] <= push.res1;
    end
  end

  assign head_valid  = (count_r != '0);
  assign head        = mem_r[rd_r];
  assign almost_full = (count_r > StallAt);

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, count_r} + (CntW+1)'(npush) - (CntW+1)'(pop)) <= (CntW+1)'(DEPTH))
    else $error("result queue overflow");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (count_r <= $past(count_r) + CntW'(1)))
    else $error("queue count rose by two while draining");
`endif

endmodule

`default_nettype wire

### src/utf8_stream_decoder.sv
// Top level of the byte-serial UTF-8 decoder: input register, decode, result queue.
//
//   channel  dir  handshake          payload
//   in_      in   in_valid/in_stall  in_byte_in[7:0], in_end_of_text
//   out_     out  out_valid/out_stall out_code_point[41:0], out_malformed,
//                                     out_last_of_run
//
// One word is accepted per cycle while in_stall is low; its results are decoded in
// the cycle after acceptance and land in the result queue. A word gives zero, one
// or two results; the output drains one a cycle while out_stall is low, so a run
// of two-result words is limited by the output port. Stall the input once the
// queue holds more than DEPTH-4 entries.
// Reset (rst_n low, synchronous) clears the pending sequence and empties the queue.
`default_nettype none

module utf8_stream_decoder #(
  parameter int unsigned DEPTH = utf8d_pkg::OutqDepth
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [utf8d_pkg::ByteW-1:0] in_byte_in,
  input  wire logic                        in_end_of_text,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [utf8d_pkg::CpW-1:0]        out_code_point,
  output logic                             out_malformed,
  output logic                             out_last_of_run
);

  utf8d_pkg::push_t   push;
  utf8d_pkg::result_t head;
  logic               in_take;
  logic               almost_full;

  // Hold the input while the queue may not absorb two more words' results.
  assign in_stall = almost_full;
  assign in_take  = in_valid && !in_stall;

  utf8d_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_byte (in_byte_in),
    .in_eot  (in_end_of_text),
    .push    (push)
  );

  utf8d_outq #(
    .DEPTH (DEPTH)
  ) u_outq (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .pop_stall   (out_stall),
    .head_valid  (out_valid),
    .head        (head),
    .almost_full (almost_full)
  );

  assign out_code_point  = head.code_point;
  assign out_malformed   = head.malformed;
  assign out_last_of_run = head.last_of_run;

endmodule

`default_nettype wire
